### design/tgard_pkg.sv
// ----------------------------------------------------------------------------
// tgard_pkg
// shared types and constants for the byte-serial tga decoder
// ----------------------------------------------------------------------------
package tgard_pkg;

  // header layout
  localparam int unsigned HeaderLen = 18;
  localparam int unsigned SigLen    = 12;

  localparam logic [4:0] IdxSigType = 5'd2;
  localparam logic [4:0] IdxWidthLo = 5'd12;
  localparam logic [4:0] IdxWidthHi = 5'd13;
  localparam logic [4:0] IdxHeightLo = 5'd14;
  localparam logic [4:0] IdxHeightHi = 5'd15;
  localparam logic [4:0] IdxDepth   = 5'd16;
  localparam logic [4:0] IdxLast    = 5'(HeaderLen - 1);
  localparam logic [4:0] IdxSigEnd  = 5'(SigLen);

  // byte values of interest
  localparam logic [7:0] TypePlain = 8'd2;
  localparam logic [7:0] TypeRle   = 8'd10;
  localparam logic [7:0] Depth24   = 8'd24;
  localparam logic [7:0] Depth32   = 8'd32;

  // error codes
  localparam logic ErrDepth = 1'b0;
  localparam logic ErrType  = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RAW,
    PH_PKT_HDR,
    PH_PKT_DATA,
    PH_DONE
  } phase_e;

  // classified input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       is_zero;
    logic       is_plain;
    logic       is_rle;
    logic       is_d24;
    logic       is_d32;
  } tok_t;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel;
    logic [7:0]  run_length;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic        error_code;
    logic        last;
  } res_t;

endpackage

### design/tgard_fifo.sv
// ----------------------------------------------------------------------------
// tgard_fifo
// small synchronous queue on flip-flops, push/full and pop/empty
// ----------------------------------------------------------------------------
module tgard_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/tgard_front.sv
// ----------------------------------------------------------------------------
// tgard_front
// takes file bytes, tags them with the compares the parser needs, queues them
// ----------------------------------------------------------------------------
module tgard_front #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    data_byte_i,
  input  logic          file_start_i,
  input  logic          push_i,
  output logic          full_o,
  output logic          tok_valid_o,
  output tgard_pkg::tok_t tok_o,
  input  logic          tok_pop_i
);
  import tgard_pkg::*;

  tok_t tok_in;
  logic tok_empty;

  always_comb begin
    tok_in.data_byte  = data_byte_i;
    tok_in.file_start = file_start_i;
    tok_in.is_zero    = (data_byte_i == 8'd0);
    tok_in.is_plain   = (data_byte_i == TypePlain);
    tok_in.is_rle     = (data_byte_i == TypeRle);
    tok_in.is_d24     = (data_byte_i == Depth24);
    tok_in.is_d32     = (data_byte_i == Depth32);
  end

  tgard_fifo #(
    .Depth (Depth),
    .Width ($bits(tok_t))
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (tok_in),
    .full_o  (full_o),
    .pop_i   (tok_pop_i),
    .rdata_o (tok_o),
    .empty_o (tok_empty)
  );

  assign tok_valid_o = !tok_empty;

endmodule

### design/tgard_back.sv
// ----------------------------------------------------------------------------
// tgard_back
// header parser and pixel run decoder, one tagged byte per cycle unless the result queue is full
// ----------------------------------------------------------------------------
module tgard_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  tgard_pkg::tok_t tok_i,
  output logic            tok_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output tgard_pkg::res_t res_o
);
  import tgard_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [1:0]  sig_q, sig_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        d24_q, d24_d;
  logic        d32_q, d32_d;
  logic [31:0] area_q;
  logic [31:0] left_q, left_d;
  logic        alpha_q, alpha_d;
  logic        rep_q, rep_d;
  logic [7:0]  pkt_q, pkt_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] acc_q, acc_d;

  logic        advance;
  phase_e      cur_phase;
  logic [4:0]  cur_idx;
  logic [1:0]  cur_sig;
  logic [7:0]  b;
  logic [31:0] acc_new;
  logic        gath_done;
  logic        clip;
  logic [7:0]  run_len;
  logic [31:0] left_rem;
  logic        res_valid;

  assign advance   = tok_valid_i && !res_full_i;
  assign tok_pop_o = advance;
  assign res_push_o = advance && res_valid;

  // restart view of the state
  assign cur_phase = tok_i.file_start ? PH_HEADER : phase_q;
  assign cur_idx   = tok_i.file_start ? 5'd0 : idx_q;
  assign cur_sig   = tok_i.file_start ? 2'b11 : sig_q;
  assign b         = tok_i.data_byte;

  // pixel gathering
  assign acc_new   = acc_q | ({24'd0, b} << {bip_q, 3'b000});
  assign gath_done = (bip_q == 2'd3) || ((bip_q == 2'd2) && !alpha_q);

  // run length, clipped to the pixels left
  assign clip     = (left_q < {24'd0, pkt_q});
  assign run_len  = (cur_phase == PH_PKT_DATA && rep_q) ?
                    (clip ? left_q[7:0] : pkt_q) : 8'd1;
  assign left_rem = left_q - {24'd0, run_len};

  always_comb begin
    phase_d  = cur_phase;
    idx_d    = cur_idx;
    sig_d    = cur_sig;
    width_d  = width_q;
    height_d = height_q;
    d24_d    = d24_q;
    d32_d    = d32_q;
    left_d   = left_q;
    alpha_d  = alpha_q;
    rep_d    = rep_q;
    pkt_d    = pkt_q;
    bip_d    = bip_q;
    acc_d    = acc_q;
    res_valid = 1'b0;
    res_o    = '0;

    case (cur_phase)
      PH_HEADER: begin
        idx_d = cur_idx + 5'd1;
        if (cur_idx < IdxSigEnd) begin
          if (cur_idx == IdxSigType) begin
            if (!tok_i.is_plain) sig_d[0] = 1'b0;
            if (!tok_i.is_rle) sig_d[1] = 1'b0;
          end else if (!tok_i.is_zero) begin
            sig_d = 2'b00;
          end
        end else if (cur_idx == IdxWidthLo) begin
          width_d[7:0] = b;
        end else if (cur_idx == IdxWidthHi) begin
          width_d[15:8] = b;
        end else if (cur_idx == IdxHeightLo) begin
          height_d[7:0] = b;
        end else if (cur_idx == IdxHeightHi) begin
          height_d[15:8] = b;
        end else if (cur_idx == IdxDepth) begin
          d24_d = tok_i.is_d24;
          d32_d = tok_i.is_d32;
        end
        if (cur_idx == IdxLast) begin
          res_valid = 1'b1;
          res_o.last = 1'b1;
          if (!d24_q && !d32_q) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ErrDepth;
            phase_d          = PH_DONE;
          end else if (cur_sig == 2'b00) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ErrType;
            phase_d          = PH_DONE;
          end else begin
            res_o.kind      = KIND_HEADER;
            res_o.width     = width_q;
            res_o.height    = height_q;
            res_o.has_alpha = d32_q;
            res_o.last      = (area_q == 32'd0);
            alpha_d         = d32_q;
            left_d          = area_q;
            bip_d           = 2'd0;
            acc_d           = 32'd0;
            if (area_q == 32'd0) begin
              phase_d = PH_DONE;
            end else if (cur_sig[0]) begin
              phase_d = PH_RAW;
            end else begin
              phase_d = PH_PKT_HDR;
            end
          end
        end
      end
      PH_RAW, PH_PKT_DATA: begin
        bip_d = gath_done ? 2'd0 : bip_q + 2'd1;
        acc_d = acc_new;
        if (gath_done) begin
          res_valid        = 1'b1;
          res_o.kind       = KIND_RUN;
          res_o.pixel      = acc_new;
          res_o.run_length = run_len;
          res_o.last       = (left_rem == 32'd0);
          left_d           = left_rem;
          acc_d            = 32'd0;
          if (cur_phase == PH_PKT_DATA) begin
            pkt_d = rep_q ? 8'd0 : pkt_q - 8'd1;
          end
          if (left_rem == 32'd0) begin
            phase_d = PH_DONE;
          end else if (cur_phase == PH_PKT_DATA && (rep_q || pkt_q == 8'd1)) begin
            phase_d = PH_PKT_HDR;
          end
        end
      end
      PH_PKT_HDR: begin
        rep_d   = b[7];
        pkt_d   = b[7] ? {1'b0, b[6:0]} + 8'd1 : b + 8'd1;
        bip_d   = 2'd0;
        acc_d   = 32'd0;
        phase_d = PH_PKT_DATA;
      end
      PH_DONE: begin
        idx_d = cur_idx;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= 5'd0;
      sig_q   <= 2'b11;
      left_q  <= 32'd0;
      alpha_q <= 1'b0;
      rep_q   <= 1'b0;
      pkt_q   <= 8'd0;
      bip_q   <= 2'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sig_q   <= sig_d;
      left_q  <= left_d;
      alpha_q <= alpha_d;
      rep_q   <= rep_d;
      pkt_q   <= pkt_d;
      bip_q   <= bip_d;
    end
  end

  // payload registers; the image area is registered one byte after height
  always_ff @(posedge clk_i) begin
    if (advance) begin
      width_q  <= width_d;
      height_q <= height_d;
      d24_q    <= d24_d;
      d32_q    <= d32_d;
      acc_q    <= acc_d;
      area_q   <= {16'd0, width_q} * {16'd0, height_q};
    end
  end

endmodule

### design/tga_rle_image_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_image_decoder_core
// byte-serial tga decoder (uncompressed type 2 and rle type 10) giving
// header info, pixel runs and errors
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  bytes    | in        | push / full       | data_byte_i, file_start_i
//  results  | out       | pop / empty       | kind_o, pixel_o, run_length_o,
//           |           |                   | width_o, height_o, has_alpha_o,
//           |           |                   | error_code_o, last_o
//
// one byte per cycle sustained while the result queue has room; a result
// reaches the output queue from its byte through the byte queue, then the
// parser, and can be popped from there
// the parser handles each byte combinationally; the image area product is
// registered on header byte 16 and used on byte 17
// reset clears both queues and returns the parser to the start of a header
// the parser stalls only when the result queue is full; the byte side stalls
// only when the byte queue is full, so each side can wait on its own
//
module tga_rle_image_decoder_core #(
  parameter int unsigned TOKEN_DEPTH  = 4,
  parameter int unsigned RESULT_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [31:0] pixel_o,
  output logic [7:0]  run_length_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic        has_alpha_o,
  output logic        error_code_o,
  output logic        last_o
);
  import tgard_pkg::*;

  tok_t tok;
  logic tok_valid;
  logic tok_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  // front: classify and queue the incoming bytes
  tgard_front #(
    .Depth (TOKEN_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .push_i       (push),
    .full_o       (full),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok),
    .tok_pop_i    (tok_pop)
  );

  // back: header parse and run decode
  tgard_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue; a finished result waits here while the parser goes on
  tgard_fifo #(
    .Depth (RESULT_DEPTH),
    .Width ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign kind_o       = res_out.kind;
  assign pixel_o      = res_out.pixel;
  assign run_length_o = res_out.run_length;
  assign width_o      = res_out.width;
  assign height_o     = res_out.height;
  assign has_alpha_o  = res_out.has_alpha;
  assign error_code_o = res_out.error_code;
  assign last_o       = res_out.last;

endmodule

### bench/tga_rle_image_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_image_decoder_core_test
// self-checking bench for the byte-serial tga decoder: a bit-exact predictor
// follows every accepted byte, and each popped result is compared with the
// oldest predicted one; directed files cover the header checks, clipping and
// restarts, then random files run under several idle and stall mixes
// ----------------------------------------------------------------------------
module tga_rle_image_decoder_core_test;
  import tgard_pkg::*;

  localparam logic [7:0] RepeatFlag   = 8'h80;
  localparam int unsigned WatchLimit  = 3000;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxPixels   = 40;

  // predicts the result stream of the decoder and checks what comes out
  class tga_result_predictor;
    phase_e      parse_phase;
    logic [4:0]  hdr_idx;
    logic [1:0]  sig_ok;       // bit 0 plain still possible, bit 1 rle
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [31:0] px_left;
    logic [2:0]  bpp;
    logic        pkt_is_repeat;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_idx;
    logic [31:0] px_acc;
    logic [7:0]  depth;
    res_t        expected_results[$];
    int          mismatch_count;

    function new();
      mismatch_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      parse_phase   = PH_HEADER;
      hdr_idx       = '0;
      sig_ok        = 2'b11;
      img_w         = '0;
      img_h         = '0;
      px_left       = '0;
      bpp           = '0;
      pkt_is_repeat = 1'b0;
      pkt_left      = '0;
      byte_idx      = '0;
      px_acc        = '0;
      depth         = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // true when the byte completes a pixel
    function bit gather(logic [7:0] b);
      px_acc   = px_acc | (32'(b) << (8 * byte_idx));
      byte_idx = byte_idx + 2'd1;
      if (byte_idx == 2'd0 || {1'b0, byte_idx} >= bpp) begin
        byte_idx = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void emit_run(logic [31:0] len);
      res_t r;
      r            = '0;
      r.kind       = KIND_RUN;
      r.pixel      = px_acc;
      r.run_length = len[7:0];
      px_left      = px_left - len;
      r.last       = (px_left == 0);
      px_acc       = '0;
      if (px_left == 0) parse_phase = PH_DONE;
      expected_results.push_back(r);
    endfunction

    // one accepted byte transfer
    function void note_byte(logic [7:0] b, logic start);
      res_t        r;
      logic [31:0] len;
      if (start) clear_state();
      r = '0;
      case (parse_phase)
        PH_HEADER: begin
          if (hdr_idx < IdxSigEnd) begin
            if (b != ((hdr_idx == IdxSigType) ? TypePlain : 8'd0)) sig_ok[0] = 1'b0;
            if (b != ((hdr_idx == IdxSigType) ? TypeRle : 8'd0)) sig_ok[1] = 1'b0;
          end else if (hdr_idx == IdxWidthLo) begin
            img_w[7:0] = b;
          end else if (hdr_idx == IdxWidthHi) begin
            img_w[15:8] = b;
          end else if (hdr_idx == IdxHeightLo) begin
            img_h[7:0] = b;
          end else if (hdr_idx == IdxHeightHi) begin
            img_h[15:8] = b;
          end else if (hdr_idx == IdxDepth) begin
            depth = b;
          end
          if (hdr_idx != IdxLast) begin
            hdr_idx = hdr_idx + 5'd1;
            return;
          end
          hdr_idx = hdr_idx + 5'd1;
          if (depth != Depth24 && depth != Depth32) begin
            r.kind       = KIND_ERROR;
            r.error_code = ErrDepth;
            r.last       = 1'b1;
            parse_phase  = PH_DONE;
          end else if (sig_ok == 2'b00) begin
            r.kind       = KIND_ERROR;
            r.error_code = ErrType;
            r.last       = 1'b1;
            parse_phase  = PH_DONE;
          end else begin
            bpp         = (depth == Depth32) ? 3'd4 : 3'd3;
            px_left     = 32'(img_w) * 32'(img_h);
            byte_idx    = '0;
            px_acc      = '0;
            r.kind      = KIND_HEADER;
            r.width     = img_w;
            r.height    = img_h;
            r.has_alpha = (bpp == 3'd4);
            r.last      = (px_left == 0);
            if (px_left == 0) parse_phase = PH_DONE;
            else if (sig_ok[0]) parse_phase = PH_RAW;
            else parse_phase = PH_PKT_HDR;
          end
          expected_results.push_back(r);
        end
        PH_RAW: begin
          if (gather(b)) emit_run(32'd1);
        end
        PH_PKT_HDR: begin
          pkt_is_repeat = b[7];
          pkt_left      = pkt_is_repeat ? (b - 8'd127) : (b + 8'd1);
          byte_idx      = '0;
          px_acc        = '0;
          parse_phase   = PH_PKT_DATA;
        end
        PH_PKT_DATA: begin
          if (gather(b)) begin
            if (pkt_is_repeat) begin
              len      = 32'(pkt_left);
              // repeat runs never overrun the image
              if (len > px_left) len = px_left;
              pkt_left = '0;
            end else begin
              len      = 32'd1;
              pkt_left = pkt_left - 8'd1;
            end
            emit_run(len);
            if (parse_phase != PH_DONE && pkt_left == 0) parse_phase = PH_PKT_HDR;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task compare_field(string name, logic [31:0] got_val, logic [31:0] want_val);
      if (got_val !== want_val)
        report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got_val, want_val));
    endtask

    // one accepted result transfer
    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", got.kind));
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("pixel", got.pixel, want.pixel);
      compare_field("run_length", got.run_length, want.run_length);
      compare_field("width", got.width, want.width);
      compare_field("height", got.height, want.height);
      compare_field("has_alpha", got.has_alpha, want.has_alpha);
      compare_field("error_code", got.error_code, want.error_code);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        file_start_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [31:0] pixel_o;
  logic [7:0]  run_length_o;
  logic [15:0] width_o;
  logic [15:0] height_o;
  logic        has_alpha_o;
  logic        error_code_o;
  logic        last_o;

  tga_result_predictor predictor = new();

  // traffic shaping shared between the sender and the receiver
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          sent_count = 0;
  int          stuck_cycles = 0;

  // bytes of the file being built
  logic [7:0]  file_bytes[$];

  always #4 clk_i = ~clk_i;

  tga_rle_image_decoder_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .pixel_o      (pixel_o),
    .run_length_o (run_length_o),
    .width_o      (width_o),
    .height_o     (height_o),
    .has_alpha_o  (has_alpha_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  // ---------------------------------------------------------------------------
  // result side: pop decided at the falling edge, a long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every result transfer goes to the checker
  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.kind       = kind_e'(kind_o);
      got.pixel      = pixel_o;
      got.run_length = run_length_o;
      got.width      = width_o;
      got.height     = height_o;
      got.has_alpha  = has_alpha_o;
      got.error_code = error_code_o;
      got.last       = last_o;
      predictor.check_result(got);
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WatchLimit) begin
        $display("timeout: no transfer for %0d cycles", stuck_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // offer one byte, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    data_byte_i  <= b;
    file_start_i <= start;
    do @(posedge clk_i); while (full);
    predictor.note_byte(b, start);
    sent_count++;
    @(negedge clk_i);
  endtask

  // sender pauses until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk_i);
  endtask

  task automatic put_header(logic [7:0] img_type, logic [15:0] w, logic [15:0] h,
                            logic [7:0] dep);
    file_bytes.delete();
    for (int i = 0; i < SigLen; i++)
      file_bytes.push_back((i == IdxSigType) ? img_type : 8'd0);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(dep);
    // last header byte carries nothing
    file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_pixels(int count, int nbytes);
    for (int i = 0; i < count * nbytes; i++)
      file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // rle packet: a repeat packet carries one pixel, a raw one carries npix
  task automatic put_packet(bit is_repeat, int count, int nbytes, int npix);
    if (is_repeat) begin
      file_bytes.push_back(RepeatFlag | 8'(count - 1));
      put_pixels(1, nbytes);
    end else begin
      file_bytes.push_back(8'(count - 1));
      put_pixels(npix, nbytes);
    end
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // mostly well-formed files with random content, some with broken headers,
  // cut short, huge or followed by junk
  task automatic send_random_file();
    int         pick;
    int         nbytes;
    int         w;
    int         h;
    int         target;
    int         covered;
    int         cnt;
    int         npix;
    int         cut;
    bit         rle;
    logic [7:0] img_type;
    logic [7:0] dep;
    pick     = $urandom_range(99);
    rle      = $urandom_range(1);
    img_type = rle ? TypeRle : TypePlain;
    dep      = $urandom_range(1) ? Depth32 : Depth24;
    w        = $urandom_range(1, 6);
    h        = $urandom_range(1, 4);
    if (pick < 3) begin
      img_type = 8'($urandom_range(255));
    end else if (pick < 9) begin
      dep = 8'($urandom_range(255));
    end else if (pick < 12) begin
      if ($urandom_range(1)) w = 0;
      else h = 0;
    end else if (pick < 16) begin
      w = $urandom_range(0, 65535);
      h = $urandom_range(1, 65535);
    end
    put_header(img_type, 16'(w), 16'(h), dep);
    // broken signature byte anywhere in the signature
    if (pick >= 3 && pick < 6)
      file_bytes[$urandom_range(SigLen - 1)] ^= 8'($urandom_range(1, 255));
    nbytes = (dep == Depth32) ? 4 : 3;
    target = (w * h > MaxPixels) ? MaxPixels : w * h;
    if (!rle) begin
      put_pixels(target, nbytes);
    end else begin
      covered = 0;
      while (covered < target) begin
        cnt = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        if ($urandom_range(1)) begin
          put_packet(1'b1, cnt, nbytes, 1);
          covered += cnt;
        end else begin
          npix = (cnt < target - covered) ? cnt : target - covered;
          put_packet(1'b0, cnt, nbytes, npix);
          covered += npix;
        end
      end
    end
    // cut short, the next file restarts the parser
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    // junk after the image end
    if ($urandom_range(6) == 0)
      for (int i = $urandom_range(1, 5); i > 0; i--)
        file_bytes.push_back(8'($urandom_range(255)));
    send_file();
  endtask

  task automatic run_random_phase(int idle_pct, int stall_pct, int nbytes, bit hold_off);
    int start_count;
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // result side holds off while bytes keep coming, so both queues fill
    if (hold_off) hold_request = HoldCycles;
    start_count = sent_count;
    while (sent_count - start_count < nbytes) begin
      if ($urandom_range(99) < 6) send_noise($urandom_range(1, 4));
      else send_random_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte_i  = '0;
    file_start_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain 24-bit 2x1 with all-ones and all-zeros pixels
    put_header(TypePlain, 16'd2, 16'd1, Depth24);
    for (int i = 0; i < 3; i++) file_bytes.push_back(8'hff);
    for (int i = 0; i < 3; i++) file_bytes.push_back(8'h00);
    send_file();

    // rle 32-bit 3x1: raw packet of two, then a 128 repeat clipped to one pixel,
    // then junk that must be ignored
    put_header(TypeRle, 16'd3, 16'd1, Depth32);
    put_packet(1'b0, 2, 4, 2);
    put_packet(1'b1, 128, 4, 1);
    send_file();
    send_noise(2);

    // rle 24-bit 2x1: raw packet of 128 stops at the last pixel
    put_header(TypeRle, 16'd2, 16'd1, Depth24);
    put_packet(1'b0, 128, 3, 2);
    send_file();
    send_noise(3);

    // largest image, plain 32-bit, a couple of pixels then a restart
    put_header(TypePlain, 16'hffff, 16'hffff, Depth32);
    put_pixels(2, 4);
    send_file();

    // largest image, rle 32-bit, one full repeat packet, restart mid-pixel
    put_header(TypeRle, 16'hffff, 16'hffff, Depth32);
    put_packet(1'b1, 128, 4, 1);
    put_packet(1'b0, 1, 4, 1);
    void'(file_bytes.pop_back());
    send_file();

    // zero-sized image, header is the last result
    put_header(TypeRle, 16'd0, 16'h1234, Depth24);
    send_file();
    send_noise(2);

    // bad depth and bad type together: depth wins
    put_header(8'hff, 16'd1, 16'd1, 8'd0);
    send_file();
    // bad type with a good depth
    put_header(8'd3, 16'd1, 16'd1, Depth24);
    send_file();
    // depth just above 32
    put_header(TypePlain, 16'd1, 16'd1, 8'd33);
    send_file();

    // restart in the middle of a header
    put_header(TypePlain, 16'd1, 16'd1, Depth24);
    while (file_bytes.size() > 7) void'(file_bytes.pop_back());
    send_file();
    put_header(TypePlain, 16'd1, 16'd1, Depth24);
    put_pixels(1, 3);
    send_file();

    run_random_phase(0, 0, 130, 1'b1);
    run_random_phase(81, 0, 130, 1'b0);
    run_random_phase(0, 81, 130, 1'b0);
    run_random_phase(8, 8, 130, 1'b0);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (predictor.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/tgard_pkg.sv
design/tgard_fifo.sv
design/tgard_front.sv
design/tgard_back.sv
design/tga_rle_image_decoder_core.sv
bench/tga_rle_image_decoder_core_test.sv
